@@ hw/rtl/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, operation and status codes.
// Used by every module of the block; depends on nothing.
package rau_pkg;
    localparam int OPERAND_WIDTH = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZDEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd3;

    // Shared unit command and status
    typedef struct packed {
        logic start;
    } t_alu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;
endpackage

@@ hw/rtl/rau_divider.sv @@
// Shared restoring divider: one quotient bit per cycle; quotient and remainder.
// Depends on rau_pkg for the command and status structs.
module rau_divider #(
    parameter int W = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_alu_cmd   i_cmd,
    input  logic [W-1:0]        i_dividend,
    input  logic [W-1:0]        i_divisor,
    output rau_pkg::t_alu_stat  o_stat,
    output logic [W-1:0]        o_quot,
    output logic [W-1:0]        o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, r_r, r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    // Shift one dividend bit into the partial remainder and try a subtract
    assign shifted = {r_r, r_q[W-1]};
    assign trial   = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (!trial[W]) begin
                    r_r <= trial[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= shifted[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, multiplier and divider.
// Depends on rau_pkg and rau_divider.
//
//  channel  | ports                                   | handshake
//  request  | i_operation i_a_num i_a_den i_b_num ... | i_start & !o_busy
//  result   | o_res_num o_res_den o_status            | o_valid, one cycle
//
// Each pass through the shared divider on 2W-bit words runs a start cycle, the shift
// steps and a done cycle. A reduction runs one divider pass per gcd step, picks the
// gcd, then runs two divider passes to divide it out of numerator and denominator;
// a zero numerator skips the gcd. A request runs three reductions plus accept, load,
// the multiply steps, combine and done; a zero denominator or a division by zero goes from load straight to done.
// Reset is synchronous and clears the sequencer; the result strobe can't stall.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [rau_pkg::OP_W-1:0]         i_operation,
    input  logic signed [31:0]               i_a_num,
    input  logic signed [31:0]               i_a_den,
    input  logic signed [31:0]               i_b_num,
    input  logic signed [31:0]               i_b_den,
    output logic                             o_valid,
    output logic signed [31:0]               o_res_num,
    output logic [30:0]                      o_res_den,
    output logic [rau_pkg::STAT_W-1:0]       o_status
);
    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * W;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GCD, S_GWAIT, S_DIVN, S_DNW, S_DIVD, S_DDW,
        S_NEXT, S_MUL, S_COMB, S_DONE
    } t_state;

    t_state r_state;
    logic [1:0] r_phase;          // 0: operand a, 1: operand b, 2: result
    logic [1:0] r_op;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [DW-1:0] r_x, r_y, r_n, r_d, r_g;
    logic r_neg;
    logic [DW-1:0] r_ra_n, r_ra_d, r_rb_n, r_rb_d;
    logic r_ra_s, r_rb_s;
    logic [1:0] r_mstep;
    logic [DW-1:0] r_p;
    logic r_valid;
    logic [31:0] r_res_num;
    logic [30:0] r_res_den;
    logic [1:0] r_status;

    rau_pkg::t_alu_cmd  alu_cmd;
    rau_pkg::t_alu_stat alu_stat;
    logic [DW-1:0] alu_a, alu_b, alu_q, alu_r;

    rau_divider #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(alu_cmd),
        .i_dividend(alu_a), .i_divisor(alu_b),
        .o_stat(alu_stat), .o_quot(alu_q), .o_rem(alu_r)
    );

    // Magnitude of a W-bit two's complement value
    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Multiplier operand select, one W x W product per cycle
    logic [W-1:0] m_a, m_b;
    always_comb begin
        m_a = r_ra_n[W-1:0];
        m_b = r_rb_d[W-1:0];
        case (r_mstep)
            2'd0: begin
                m_a = r_ra_n[W-1:0];
                m_b = (r_op == rau_pkg::OP_MUL) ? r_rb_n[W-1:0] : r_rb_d[W-1:0];
            end
            2'd1: begin
                m_a = (r_op == rau_pkg::OP_DIV) ? r_ra_d[W-1:0] : r_rb_n[W-1:0];
                m_b = (r_op == rau_pkg::OP_DIV) ? r_rb_n[W-1:0] : r_ra_d[W-1:0];
            end
            default: begin
                m_a = r_ra_d[W-1:0];
                m_b = r_rb_d[W-1:0];
            end
        endcase
    end

    logic [DW-1:0] half;
    assign half = DW'(1) << (W - 1);

    assign alu_cmd.start  = (r_state == S_GCD) || (r_state == S_DIVN)
                            || (r_state == S_DIVD);
    always_comb begin
        alu_a = r_x;
        alu_b = r_y;
        if (r_state == S_DIVN) begin
            alu_a = r_n;
            alu_b = r_g;
        end else if (r_state == S_DIVD) begin
            alu_a = r_d;
            alu_b = r_g;
        end
    end

    // Sequencer: load, reduce a, reduce b, multiply, combine, reduce result; errors skip to done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_phase <= '0;
            r_mstep <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_op <= i_operation;
                    r_an <= i_a_num[W-1:0]; r_ad <= i_a_den[W-1:0];
                    r_bn <= i_b_num[W-1:0]; r_bd <= i_b_den[W-1:0];
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_ad == '0 || r_bd == '0) begin
                        r_status <= rau_pkg::ST_ZDEN;
                        r_state  <= S_DONE;
                    end else if (r_op == rau_pkg::OP_DIV && r_bn == '0) begin
                        r_status <= rau_pkg::ST_DIV0;
                        r_state  <= S_DONE;
                    end else begin
                        r_phase <= 2'd0;
                        r_n <= DW'(mag(r_an)); r_d <= DW'(mag(r_ad));
                        r_x <= DW'(mag(r_an)); r_y <= DW'(mag(r_ad));
                        r_neg <= r_an[W-1] ^ r_ad[W-1];
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    // zero numerator reduces straight to 0/1
                    if (r_n == '0) begin
                        r_g <= DW'(1);
                        r_d <= DW'(1);
                        r_neg <= 1'b0;
                        r_state <= S_DIVN;
                    end else if (r_y == '0) begin
                        r_g <= r_x;
                        r_state <= S_DIVN;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: r_state <= S_GWAIT;
                S_GWAIT: if (alu_stat.done) begin
                    r_x <= r_y;
                    r_y <= alu_r;
                    r_state <= S_NEXT;
                end
                S_DIVN: r_state <= S_DNW;
                S_DNW: if (alu_stat.done) begin
                    r_n <= alu_q;
                    r_state <= S_DIVD;
                end
                S_DIVD: r_state <= S_DDW;
                S_DDW: if (alu_stat.done) begin
                    case (r_phase)
                        2'd0: begin
                            r_ra_n <= r_n; r_ra_d <= alu_q; r_ra_s <= r_neg;
                            r_phase <= 2'd1;
                            r_n <= DW'(mag(r_bn)); r_d <= DW'(mag(r_bd));
                            r_x <= DW'(mag(r_bn)); r_y <= DW'(mag(r_bd));
                            r_neg <= r_bn[W-1] ^ r_bd[W-1];
                            r_state <= S_NEXT;
                        end
                        2'd1: begin
                            r_rb_n <= r_n; r_rb_d <= alu_q; r_rb_s <= r_neg;
                            r_mstep <= 2'd0;
                            r_state <= S_MUL;
                        end
                        default: begin
                            if ((r_neg ? (r_n > half) : (r_n > half - 1'b1))
                                || alu_q > half - 1'b1) begin
                                r_status <= rau_pkg::ST_OVF;
                            end else begin
                                r_status  <= rau_pkg::ST_OK;
                                r_res_num <= 32'($signed(r_neg ? (~r_n[W-1:0] + 1'b1)
                                                                : r_n[W-1:0]));
                                r_res_den <= 31'(alu_q[W-2:0]);
                            end
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_MUL: begin
                    r_p <= DW'(m_a) * DW'(m_b);
                    r_mstep <= r_mstep + 1'b1;
                    case (r_mstep)
                        2'd0: ;
                        2'd1: r_x <= r_p;
                        2'd2: r_y <= r_p;
                        default: begin
                            r_d <= r_p;
                            r_state <= S_COMB;
                        end
                    endcase
                end
                S_COMB: begin
                    r_phase <= 2'd2;
                    if (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB) begin
                        logic xs, ys;
                        xs = (r_x == '0) ? 1'b0 : r_ra_s;
                        ys = (r_y == '0) ? 1'b0
                             : ((r_op == rau_pkg::OP_SUB) ? !r_rb_s : r_rb_s);
                        if (xs == ys) begin
                            r_n <= r_x + r_y; r_x <= r_x + r_y; r_neg <= xs;
                        end else if (r_x >= r_y) begin
                            r_n <= r_x - r_y; r_x <= r_x - r_y; r_neg <= xs;
                        end else begin
                            r_n <= r_y - r_x; r_x <= r_y - r_x; r_neg <= ys;
                        end
                        r_y <= r_d;
                    end else begin
                        r_n <= r_x; r_neg <= r_ra_s ^ r_rb_s;
                        if (r_op == rau_pkg::OP_DIV) r_d <= r_y;
                        r_y <= (r_op == rau_pkg::OP_DIV) ? r_y : r_d;
                    end
                    r_state <= S_NEXT;
                end
                S_DONE: begin
                    if (r_status != rau_pkg::ST_OK) begin
                        r_res_num <= '0;
                        r_res_den <= 31'd1;
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result strobe while busy");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rau_pkg::ST_OK) |-> (o_res_den == 31'd1 && o_res_num == 0))
        else $error("error result not 0/1");
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res_den != '0)) else $error("zero result denominator");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_cmd.start |-> !alu_stat.busy) else $error("divider started while busy");
endmodule
